// ===== rtl/core/pwfp_pkg.sv =====
// Package for the protobuf wire field parser: payload types, codes and limits.
package pwfp_pkg;

	localparam int unsigned MAX_MESSAGE_BYTES_DEF = 65536;
	localparam int unsigned POS_W = 17;

	localparam logic [2:0] PH_TAG     = 3'd0;
	localparam logic [2:0] PH_VARINT  = 3'd1;
	localparam logic [2:0] PH_FIXED   = 3'd2;
	localparam logic [2:0] PH_LENGTH  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TRUNC     = 3'd1;
	localparam logic [2:0] ERR_OVERLONG  = 3'd2;
	localparam logic [2:0] ERR_FIELD_NUM = 3'd3;
	localparam logic [2:0] ERR_WIRE_TYPE = 3'd4;
	localparam logic [2:0] ERR_LEN_LARGE = 3'd5;
	localparam logic [2:0] ERR_MSG_LONG  = 3'd6;

	localparam logic KIND_FIELD = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_end;
	} msg_byte_t;

	typedef struct packed {
		logic        record_kind;
		logic [28:0] field_number;
		logic [2:0]  wire_kind;
		logic [63:0] scalar_value;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
		logic [2:0]  error_code;
		logic        closes_message;
	} record_t;

endpackage

// ===== rtl/core/pwfp_stream_if.sv =====
// Valid/ready stream interface that carries one request payload per handshake.
interface pwfp_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/protobuf_wire_field_parser.sv =====
// Protobuf wire field parser: decodes tags, scalars and length-delimited fields byte by byte.
//
// The parser takes one message byte per clock cycle and never stalls on its own: every
// byte is decoded in a single combinational pass between an input register and a result
// register, so a field record or error record is presented from the result register once
// the byte that completes it has passed through the input register and been decoded.
// Input is held back only while the result register holds a record that the sink has not
// taken. Messages are limited to MAX_MESSAGE_BYTES bytes, capped at 65536 since offsets
// and lengths are 16 bits. After an error, bytes are dropped silently up to and including
// the message's last byte.
module protobuf_wire_field_parser
	import pwfp_pkg::*;
#(
	parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	pwfp_stream_if.sink   msg,
	pwfp_stream_if.source rec
);

	localparam int unsigned LIMIT_INT = (MAX_MESSAGE_BYTES > 65536) ? 65536 : MAX_MESSAGE_BYTES;
	localparam logic [POS_W-1:0] LIMIT = POS_W'(LIMIT_INT);

	logic            valid_s1;
	msg_byte_t       data_s1;
	logic            adv;
	logic            rec_valid_q;
	record_t         rec_q;

	logic [2:0]       phase_q, nx_phase;
	logic [63:0]      acc_q, nx_acc;
	logic [3:0]       grp_q, nx_grp;
	logic [28:0]      fn_q, nx_fn;
	logic [2:0]       wk_q, nx_wk;
	logic [POS_W-1:0] pos_q, nx_pos;
	logic [15:0]      rem_q, nx_rem;
	logic [POS_W-1:0] pstart_q, nx_pstart;
	logic             drop_q, nx_drop;

	logic             emit;
	record_t          res;

	logic [7:0]       b;
	logic             last;
	logic [6:0]       sh7_full;
	logic [5:0]       sh7;
	logic [5:0]       sh8;
	logic [63:0]      acc_v;
	logic [63:0]      acc_f;
	logic             overlong;
	logic [15:0]      rem_d;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] room;

	assign b        = data_s1.data_byte;
	assign last     = data_s1.message_end;
	assign sh7_full = 7'(grp_q) * 7'd7;
	assign sh7      = sh7_full[5:0];
	assign sh8      = {grp_q[2:0], 3'b000};
	assign acc_v    = acc_q | (64'(b[6:0]) << sh7);
	assign acc_f    = acc_q | (64'(b) << sh8);
	assign overlong = (grp_q >= 4'd9) && (b > 8'd1);
	assign rem_d    = (rem_q != 16'd0) ? rem_q - 16'd1 : 16'd0;
	assign pos_inc  = pos_q + POS_W'(1);
	assign room     = LIMIT - pos_inc;

	assign adv       = valid_s1 && (!rec_valid_q || rec.ready);
	assign msg.ready = !valid_s1 || adv;
	assign rec.valid = rec_valid_q;
	assign rec.data  = rec_q;

	always_comb begin
		logic err;
		logic done;
		logic clr_fld;
		logic clr_msg;
		logic [2:0] ecode;

		nx_phase  = phase_q;
		nx_acc    = acc_q;
		nx_grp    = grp_q;
		nx_fn     = fn_q;
		nx_wk     = wk_q;
		nx_pos    = pos_q;
		nx_rem    = rem_q;
		nx_pstart = pstart_q;
		nx_drop   = drop_q;
		emit      = 1'b0;
		res       = '0;
		err       = 1'b0;
		done      = 1'b0;
		clr_fld   = 1'b0;
		clr_msg   = 1'b0;
		ecode     = ERR_NONE;

		if (drop_q) begin
			clr_msg = last;
		end else if (pos_q >= LIMIT) begin
			err   = 1'b1;
			ecode = ERR_MSG_LONG;
		end else begin
			nx_pos = pos_inc;
			case (phase_q)
				PH_TAG: begin
					if (overlong) begin
						err   = 1'b1;
						ecode = ERR_OVERLONG;
					end else if (!b[7]) begin
						if ((acc_v[63:32] != 32'd0) || (acc_v[63:3] == 61'd0)) begin
							err   = 1'b1;
							ecode = ERR_FIELD_NUM;
						end else begin
							nx_fn  = acc_v[31:3];
							nx_wk  = acc_v[2:0];
							nx_acc = '0;
							nx_grp = '0;
							case (acc_v[2:0])
								WT_VARINT: nx_phase = PH_VARINT;
								WT_FIXED64: begin
									nx_phase = PH_FIXED;
									nx_rem   = 16'd8;
								end
								WT_FIXED32: begin
									nx_phase = PH_FIXED;
									nx_rem   = 16'd4;
								end
								WT_LEN: nx_phase = PH_LENGTH;
								default: begin
									err   = 1'b1;
									ecode = ERR_WIRE_TYPE;
								end
							endcase
						end
					end else begin
						nx_acc = acc_v;
						nx_grp = grp_q + 4'd1;
					end
				end
				PH_VARINT: begin
					if (overlong) begin
						err   = 1'b1;
						ecode = ERR_OVERLONG;
					end else if (!b[7]) begin
						done             = 1'b1;
						res.scalar_value = acc_v;
					end else begin
						nx_acc = acc_v;
						nx_grp = grp_q + 4'd1;
					end
				end
				PH_FIXED: begin
					nx_acc = acc_f;
					nx_grp = grp_q + 4'd1;
					nx_rem = rem_d;
					if (rem_d == 16'd0) begin
						done             = 1'b1;
						res.scalar_value = acc_f;
					end
				end
				PH_LENGTH: begin
					if (overlong) begin
						err   = 1'b1;
						ecode = ERR_OVERLONG;
					end else if (!b[7]) begin
						if ((acc_v[63:16] != 48'd0) || (acc_v[POS_W-1:0] > room)) begin
							err   = 1'b1;
							ecode = ERR_LEN_LARGE;
						end else begin
							nx_pstart = pos_inc;
							nx_rem    = acc_v[15:0];
							if (acc_v[15:0] == 16'd0) begin
								done               = 1'b1;
								res.payload_offset = pos_inc[15:0];
							end else begin
								nx_phase = PH_PAYLOAD;
							end
						end
					end else begin
						nx_acc = acc_v;
						nx_grp = grp_q + 4'd1;
					end
				end
				default: begin
					nx_rem = rem_d;
					if (rem_d == 16'd0) begin
						done               = 1'b1;
						res.payload_offset = pstart_q[15:0];
						res.payload_length = 16'(pos_inc - pstart_q);
					end
				end
			endcase
			// A message that ends inside a field with nothing else to report is truncated.
			if (!done && !err && last) begin
				err   = 1'b1;
				ecode = ERR_TRUNC;
			end
		end

		if (err) begin
			emit               = 1'b1;
			res                = '0;
			res.record_kind    = KIND_ERROR;
			res.error_code     = ecode;
			res.closes_message = last;
			if (last) begin
				clr_msg = 1'b1;
			end else begin
				nx_drop = 1'b1;
			end
		end else if (done) begin
			emit               = 1'b1;
			res.record_kind    = KIND_FIELD;
			res.field_number   = fn_q;
			res.wire_kind      = wk_q;
			res.error_code     = ERR_NONE;
			res.closes_message = last;
			clr_msg            = last;
			clr_fld            = !last;
		end

		if (clr_fld || clr_msg) begin
			nx_phase = PH_TAG;
			nx_acc   = '0;
			nx_grp   = '0;
			nx_rem   = '0;
		end
		if (clr_msg) begin
			nx_fn     = '0;
			nx_wk     = '0;
			nx_pos    = '0;
			nx_pstart = '0;
			nx_drop   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			data_s1 <= msg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			acc_q    <= '0;
			grp_q    <= '0;
			fn_q     <= '0;
			wk_q     <= '0;
			pos_q    <= '0;
			rem_q    <= '0;
			pstart_q <= '0;
			drop_q   <= 1'b0;
		end else if (adv) begin
			phase_q  <= nx_phase;
			acc_q    <= nx_acc;
			grp_q    <= nx_grp;
			fn_q     <= nx_fn;
			wk_q     <= nx_wk;
			pos_q    <= nx_pos;
			rem_q    <= nx_rem;
			pstart_q <= nx_pstart;
			drop_q   <= nx_drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (adv && emit) begin
			rec_valid_q <= 1'b1;
		end else if (rec.ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			rec_q <= res;
		end
	end

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid_q && rec_q.record_kind == KIND_ERROR) |->
		(rec_q.error_code != ERR_NONE && rec_q.field_number == 29'd0 &&
		 rec_q.scalar_value == 64'd0))
		else $error("error record carries field data or no code");

	a_field_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid_q && rec_q.record_kind == KIND_FIELD) |->
		(rec_q.error_code == ERR_NONE && rec_q.field_number != 29'd0 &&
		 (rec_q.wire_kind == WT_VARINT || rec_q.wire_kind == WT_FIXED64 ||
		  rec_q.wire_kind == WT_LEN || rec_q.wire_kind == WT_FIXED32)))
		else $error("field record with bad number, wire type or code");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LIMIT)
		else $error("byte position past message limit");

	a_grp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_FIXED) |-> (grp_q <= 4'd9))
		else $error("varint group count past ten groups");

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid_q && !rec.ready) |=> (rec_valid_q && $stable(rec_q)))
		else $error("stalled record changed");

endmodule

// ===== dv/tb_protobuf_wire_field_parser.sv =====
// Testbench for the protobuf wire field parser: directed table, then random messages.
module tb_protobuf_wire_field_parser;
	import pwfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SIZE_LIMIT =
		(MAX_MESSAGE_BYTES_DEF > 65536) ? 65536 : MAX_MESSAGE_BYTES_DEF;
	localparam int unsigned RANDOM_BYTES = 2000;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef enum logic [1:0] {GRP_MORE, GRP_DONE, GRP_OVERLONG} group_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       last;
		bit         typed;
		record_t    want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	pwfp_stream_if #(.payload_t(msg_byte_t)) msg_if ();
	pwfp_stream_if #(.payload_t(record_t)) rec_if ();

	protobuf_wire_field_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_if),
		.rec(rec_if)
	);

	// Decoder state mirrored from the block.
	logic [2:0]  st_phase;
	logic [63:0] acc;
	int unsigned groups;
	logic [28:0] held_field;
	logic [2:0]  held_wire;
	int unsigned pos;
	int unsigned remaining;
	int unsigned payload_at;
	bit          dropping;

	record_t     record_q[$];
	logic [7:0]  msg_q[$];
	stim_row_t   directed_q[$];

	bit          typed_chk;
	record_t     typed_want;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned errors;
	int unsigned cycles;
	int unsigned live_bytes;
	int unsigned messages;
	int unsigned field_records;
	int unsigned error_records;

	always #2 clk = ~clk;

	function automatic void clear_field();
		st_phase = PH_TAG;
		acc = '0;
		groups = 0;
		remaining = 0;
	endfunction

	function automatic void clear_message();
		clear_field();
		held_field = '0;
		held_wire = '0;
		pos = 0;
		payload_at = 0;
		dropping = 1'b0;
	endfunction

	function automatic group_t take_group(input logic [7:0] b);
		if (groups >= 9 && b > 8'd1)
			return GRP_OVERLONG;
		acc |= 64'(b[6:0]) << ((7 * groups) & 63);
		if (!b[7])
			return GRP_DONE;
		groups++;
		return GRP_MORE;
	endfunction

	function automatic bit error_record(input logic [2:0] code, input logic last,
			output record_t r);
		r = '0;
		r.record_kind = KIND_ERROR;
		r.error_code = code;
		r.closes_message = last;
		if (last)
			clear_message();
		else
			dropping = 1'b1;
		return 1'b1;
	endfunction

	function automatic void field_record(input logic [63:0] value, input int unsigned off,
			input int unsigned len, input logic last, output record_t r);
		r = '0;
		r.record_kind = KIND_FIELD;
		r.field_number = held_field;
		r.wire_kind = held_wire;
		r.scalar_value = value;
		r.payload_offset = off[15:0];
		r.payload_length = len[15:0];
		r.error_code = ERR_NONE;
		r.closes_message = last;
	endfunction

	// Advances the decoder by one byte; returns 1 when the byte yields a record.
	function automatic bit decode_byte(input logic [7:0] b, input logic last,
			output record_t r);
		group_t      g;
		bit          done;
		logic [63:0] fnum;
		int unsigned room;
		r = '0;
		done = 1'b0;
		if (dropping) begin
			if (last)
				clear_message();
			return 1'b0;
		end
		if (pos >= SIZE_LIMIT)
			return error_record(ERR_MSG_LONG, last, r);
		pos++;
		case (st_phase)
			PH_TAG: begin
				g = take_group(b);
				if (g == GRP_OVERLONG)
					return error_record(ERR_OVERLONG, last, r);
				if (g == GRP_DONE) begin
					fnum = acc >> 3;
					if (fnum == 0 || fnum > 64'h1FFF_FFFF)
						return error_record(ERR_FIELD_NUM, last, r);
					held_field = fnum[28:0];
					held_wire = acc[2:0];
					acc = '0;
					groups = 0;
					case (held_wire)
						WT_VARINT: st_phase = PH_VARINT;
						WT_FIXED64: begin
							st_phase = PH_FIXED;
							remaining = 8;
						end
						WT_FIXED32: begin
							st_phase = PH_FIXED;
							remaining = 4;
						end
						WT_LEN: st_phase = PH_LENGTH;
						default: return error_record(ERR_WIRE_TYPE, last, r);
					endcase
				end
			end
			PH_VARINT: begin
				g = take_group(b);
				if (g == GRP_OVERLONG)
					return error_record(ERR_OVERLONG, last, r);
				if (g == GRP_DONE) begin
					field_record(acc, 0, 0, last, r);
					done = 1'b1;
				end
			end
			PH_FIXED: begin
				acc |= 64'(b) << ((8 * groups) & 63);
				groups = (groups + 1) & 15;
				if (remaining > 0)
					remaining--;
				if (remaining == 0) begin
					field_record(acc, 0, 0, last, r);
					done = 1'b1;
				end
			end
			PH_LENGTH: begin
				g = take_group(b);
				if (g == GRP_OVERLONG)
					return error_record(ERR_OVERLONG, last, r);
				if (g == GRP_DONE) begin
					room = SIZE_LIMIT - pos;
					if (acc > 64'd65535 || acc > 64'(room))
						return error_record(ERR_LEN_LARGE, last, r);
					payload_at = pos;
					remaining = int'(acc[15:0]);
					if (remaining == 0) begin
						field_record('0, payload_at, 0, last, r);
						done = 1'b1;
					end else begin
						st_phase = PH_PAYLOAD;
					end
				end
			end
			default: begin
				if (remaining > 0)
					remaining--;
				if (remaining == 0) begin
					field_record('0, payload_at, pos - payload_at, last, r);
					done = 1'b1;
				end
			end
		endcase
		if (done) begin
			if (last)
				clear_message();
			else
				clear_field();
			return 1'b1;
		end
		if (last)
			return error_record(ERR_TRUNC, 1'b1, r);
		return 1'b0;
	endfunction

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	task automatic check_record(input record_t got, input record_t want);
		if (got.record_kind !== want.record_kind)
			report($sformatf("record_kind %0b, expected %0b", got.record_kind,
				want.record_kind));
		if (got.field_number !== want.field_number)
			report($sformatf("field_number %0d, expected %0d", got.field_number,
				want.field_number));
		if (got.wire_kind !== want.wire_kind)
			report($sformatf("wire_kind %0d, expected %0d", got.wire_kind, want.wire_kind));
		if (got.scalar_value !== want.scalar_value)
			report($sformatf("scalar_value %h, expected %h", got.scalar_value,
				want.scalar_value));
		if (got.payload_offset !== want.payload_offset)
			report($sformatf("payload_offset %0d, expected %0d", got.payload_offset,
				want.payload_offset));
		if (got.payload_length !== want.payload_length)
			report($sformatf("payload_length %0d, expected %0d", got.payload_length,
				want.payload_length));
		if (got.error_code !== want.error_code)
			report($sformatf("error_code %0d, expected %0d", got.error_code,
				want.error_code));
		if (got.closes_message !== want.closes_message)
			report($sformatf("closes_message %0b, expected %0b", got.closes_message,
				want.closes_message));
	endtask

	// Every accepted request goes through the decoder; every accepted record is compared.
	always @(posedge clk) begin
		record_t r;
		bit      has;
		if (arst_n) begin
			if (msg_if.valid && msg_if.ready) begin
				if (!dropping)
					live_bytes <= live_bytes + 1;
				if (msg_if.data.message_end)
					messages <= messages + 1;
				has = decode_byte(msg_if.data.data_byte, msg_if.data.message_end, r);
				if (typed_chk)
					record_q = {record_q, typed_want};
				else if (has)
					record_q = {record_q, r};
			end
			if (rec_if.valid && rec_if.ready) begin
				if (rec_if.data.record_kind == KIND_ERROR)
					error_records++;
				else
					field_records++;
				if (record_q.size() == 0)
					report("record arrived with nothing expected");
				else
					check_record(rec_if.data, record_q.pop_front());
			end
		end
	end

	always @(posedge clk)
		rec_if.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic record_t err_rec(input logic [2:0] code, input logic closes);
		record_t r;
		r = '0;
		r.record_kind = KIND_ERROR;
		r.error_code = code;
		r.closes_message = closes;
		return r;
	endfunction

	function automatic record_t fld_rec(input logic [28:0] fn, input logic [2:0] wt,
			input logic [63:0] value, input logic [15:0] off, input logic [15:0] len,
			input logic closes);
		record_t r;
		r = '0;
		r.record_kind = KIND_FIELD;
		r.field_number = fn;
		r.wire_kind = wt;
		r.scalar_value = value;
		r.payload_offset = off;
		r.payload_length = len;
		r.closes_message = closes;
		return r;
	endfunction

	function automatic void row(input logic [7:0] d, input logic last, input bit typed = 1'b0,
			input record_t want = '0);
		stim_row_t s;
		s.data_byte = d;
		s.last = last;
		s.typed = typed;
		s.want = want;
		directed_q = {directed_q, s};
	endfunction

	function automatic void put_varint(input logic [63:0] v, input int unsigned min_groups);
		int unsigned n;
		logic [7:0]  g;
		n = 0;
		do begin
			g = {1'b0, v[6:0]};
			v = v >> 7;
			n++;
			if (v != 0 || n < min_groups)
				g[7] = 1'b1;
			msg_q = {msg_q, g};
		end while (g[7]);
	endfunction

	function automatic int unsigned pad_groups();
		return ($urandom_range(7) == 0) ? $urandom_range(1, 10) : 1;
	endfunction

	function automatic logic [63:0] rand_value();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return {$urandom, $urandom};
			default: return {$urandom, $urandom} >> $urandom_range(63);
		endcase
	endfunction

	function automatic void put_random_bytes(input int unsigned n);
		repeat (n) msg_q = {msg_q, 8'($urandom_range(255))};
	endfunction

	function automatic void put_field();
		logic [2:0]  wt;
		logic [28:0] fn;
		int unsigned n;
		case ($urandom_range(3))
			0: wt = WT_VARINT;
			1: wt = WT_FIXED64;
			2: wt = WT_LEN;
			default: wt = WT_FIXED32;
		endcase
		case ($urandom_range(9))
			0: fn = 29'd1;
			1: fn = '1;
			2, 3, 4, 5, 6: fn = 29'($urandom_range(1, 15));
			default: fn = 29'($urandom_range(1, 29'h1FFF_FFFF));
		endcase
		put_varint({32'b0, fn, wt}, pad_groups());
		case (wt)
			WT_VARINT: put_varint(rand_value(), pad_groups());
			WT_FIXED64: put_random_bytes(8);
			WT_FIXED32: put_random_bytes(4);
			default: begin
				n = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
				put_varint(64'(n), pad_groups());
				put_random_bytes(n);
			end
		endcase
	endfunction

	// Mostly well-formed messages; the rest are cut short, malformed or plain noise.
	function automatic void build_message();
		int unsigned nf;
		logic [2:0]  bad_wt;
		msg_q.delete();
		nf = $urandom_range(1, 4);
		if ($urandom_range(99) < 78) begin
			repeat (nf) put_field();
			return;
		end
		case ($urandom_range(4))
			0: begin
				repeat (nf) put_field();
				repeat ($urandom_range(1, msg_q.size() - 1)) void'(msg_q.pop_back());
				if (msg_q.size() == 0)
					put_random_bytes(1);
			end
			1: begin
				if ($urandom_range(1))
					put_field();
				case ($urandom_range(3))
					0: bad_wt = 3'd3;
					1: bad_wt = 3'd4;
					2: bad_wt = 3'd6;
					default: bad_wt = 3'd7;
				endcase
				case ($urandom_range(2))
					0: put_varint({32'b0, 29'($urandom_range(1, 200)), bad_wt}, pad_groups());
					1: put_varint(64'($urandom_range(7)), pad_groups());
					default: put_varint(rand_value() | (64'd1 << (32 + $urandom_range(31))),
						pad_groups());
				endcase
				put_field();
			end
			2: begin
				case ($urandom_range(2))
					0: msg_q = {msg_q, 8'h08};
					1: msg_q = {msg_q, 8'h12};
					default: ;
				endcase
				repeat (9) msg_q = {msg_q, 8'h80 | 8'($urandom_range(127))};
				msg_q = {msg_q, 8'($urandom_range(2, 255))};
				put_random_bytes($urandom_range(0, 3));
			end
			3: begin
				put_varint({32'b0, 29'($urandom_range(1, 1000)), WT_LEN}, 1);
				case ($urandom_range(2))
					0: put_varint(64'($urandom_range(SIZE_LIMIT - 3, 65535)), 1);
					1: put_varint(64'd65536 + 64'($urandom_range(0, 1 << 20)), 1);
					default: put_varint(rand_value() | (64'd1 << 16), 1);
				endcase
				put_random_bytes($urandom_range(1, 4));
			end
			default: put_random_bytes($urandom_range(1, 12));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] d, input logic last, input bit typed,
			input record_t want);
		while ($urandom_range(99) < idle_pct) begin
			msg_if.valid <= 1'b0;
			@(posedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.data <= '{data_byte: d, message_end: last};
		typed_chk <= typed;
		typed_want <= want;
		do @(posedge clk); while (!msg_if.ready);
	endtask

	task automatic send_message();
		foreach (msg_q[i])
			send_byte(msg_q[i], i == msg_q.size() - 1, 1'b0, '0);
	endtask

	// Holds the sender off until every expected record has been taken.
	task automatic drain();
		msg_if.valid <= 1'b0;
		typed_chk <= 1'b0;
		do @(posedge clk); while (record_q.size() != 0);
	endtask

	initial begin
		int unsigned start;
		clk = 1'b0;
		arst_n = 1'b0;
		msg_if.valid = 1'b0;
		msg_if.data = '0;
		rec_if.ready = 1'b0;
		typed_chk = 1'b0;
		typed_want = '0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		cycles = 0;
		live_bytes = 0;
		messages = 0;
		field_records = 0;
		error_records = 0;
		clear_message();

		row(8'h00, 1'b0, 1'b1, err_rec(ERR_FIELD_NUM, 1'b0));
		row(8'h55, 1'b1);
		// A group wire type on the closing byte reports but starts no drop.
		row(8'h0B, 1'b1, 1'b1, err_rec(ERR_WIRE_TYPE, 1'b1));
		row(8'h0D, 1'b0);
		row(8'h78, 1'b0);
		row(8'h56, 1'b0);
		row(8'h34, 1'b0);
		row(8'h12, 1'b1, 1'b1, fld_rec(29'd1, WT_FIXED32, 64'h1234_5678, 16'd0, 16'd0, 1'b1));
		row(8'h12, 1'b0);
		row(8'h00, 1'b1, 1'b1, fld_rec(29'd2, WT_LEN, 64'd0, 16'd2, 16'd0, 1'b1));
		row(8'h1A, 1'b0);
		row(8'h02, 1'b0);
		row(8'hFF, 1'b0);
		row(8'h00, 1'b0, 1'b1, fld_rec(29'd3, WT_LEN, 64'd0, 16'd2, 16'd2, 1'b0));
		row(8'h08, 1'b1, 1'b1, err_rec(ERR_TRUNC, 1'b1));
		row(8'h80, 1'b0);
		row(8'h80, 1'b0);
		row(8'h80, 1'b0);
		row(8'h80, 1'b0);
		row(8'h10, 1'b1, 1'b1, err_rec(ERR_FIELD_NUM, 1'b1));
		row(8'h12, 1'b0);
		row(8'h80, 1'b0);
		row(8'h80, 1'b0);
		row(8'h04, 1'b0, 1'b1, err_rec(ERR_LEN_LARGE, 1'b0));
		row(8'hFF, 1'b1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i])
			send_byte(directed_q[i].data_byte, directed_q[i].last, directed_q[i].typed,
				directed_q[i].want);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 78; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			start = live_bytes;
			while (live_bytes - start < RANDOM_BYTES / 4) begin
				build_message();
				send_message();
			end
			drain();
		end

		idle_pct = 0;
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (record_q.size() != 0)
			report($sformatf("%0d expected records never arrived", record_q.size()));

		$display("Sent %0d messages with %0d decoded bytes, directed and random.",
			messages, live_bytes);
		$display("Compared %0d field records and %0d error records across four idle patterns.",
			field_records, error_records);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== protobuf_wire_field_parser.f =====
rtl/core/pwfp_pkg.sv
rtl/core/pwfp_stream_if.sv
rtl/core/protobuf_wire_field_parser.sv
dv/tb_protobuf_wire_field_parser.sv
